FILE: rtl/mats_pkg.sv
// ----------------------------------------------------------------------------
// mats_pkg
// Shared constants, codes and wrap helpers for the turmite step core.
// ----------------------------------------------------------------------------
package mats_pkg;

    localparam int GRID_W  = 64;
    localparam int GRID_H  = 32;
    localparam int ANT_N   = 4;
    localparam int RULE_D  = 512;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int ANT_W   = 2;
    localparam int CODE_W  = 9;
    localparam int MOVE_W  = 3;
    localparam int CMD_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP   = 3'd0,
        CMD_WCELL  = 3'd1,
        CMD_RCELL  = 3'd2,
        CMD_WRULE  = 3'd3,
        CMD_SETPOS = 3'd4
    } t_cmd;

    // step direction along one axis
    typedef enum logic [1:0] {
        DIR_DEC  = 2'd0,
        DIR_KEEP = 2'd1,
        DIR_INC  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDREQ,
        ST_RDOUT,
        ST_LOAD,
        ST_NBR,
        ST_RULE_RD,
        ST_MOVE
    } t_state;

    // column and row step for each move code
    localparam t_dir MOVE_DC [8] = '{DIR_DEC, DIR_KEEP, DIR_INC, DIR_DEC,
                                     DIR_INC, DIR_DEC,  DIR_KEEP, DIR_INC};
    localparam t_dir MOVE_DR [8] = '{DIR_DEC, DIR_DEC,  DIR_DEC, DIR_KEEP,
                                     DIR_KEEP, DIR_INC, DIR_INC, DIR_INC};

    function automatic logic [COL_W-1:0] wrap_col(input logic [COL_W-1:0] v,
                                                  input t_dir d);
        logic [COL_W-1:0] res;
        case (d)
            DIR_DEC: res = (v == '0) ? COL_W'(GRID_W - 1) : v - 1'b1;
            DIR_INC: res = (int'(v) + 1 >= GRID_W) ? '0 : v + 1'b1;
            default: res = v;
        endcase
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] v,
                                                  input t_dir d);
        logic [ROW_W-1:0] res;
        case (d)
            DIR_DEC: res = (v == '0) ? ROW_W'(GRID_H - 1) : v - 1'b1;
            DIR_INC: res = (int'(v) + 1 >= GRID_H) ? '0 : v + 1'b1;
            default: res = v;
        endcase
        return res;
    endfunction

    function automatic logic in_grid(input logic [COL_W-1:0] c,
                                     input logic [ROW_W-1:0] r);
        return (int'(c) < GRID_W) && (int'(r) < GRID_H);
    endfunction

endpackage

FILE: rtl/multi_ant_turmite_step_core.sv
// ----------------------------------------------------------------------------
// multi_ant_turmite_step_core
// Several turmites on a wrapping one-bit grid, each with its own rule table.
// A step command advances every turmite in turn, lowest index first, and
// later turmites see the cells toggled by earlier ones. Each turmite reads
// its 3x3 neighbourhood one grid row per cycle through a single row-wide
// read port (wrap unit shared for the row address), looks up a move in the
// rule memory, toggles its cell and moves, then emits one result item; the
// last one carries tlast. The work per turmite is the three row reads, the
// rule memory read and the toggle write; each memory has one read port
// and one write port. After reset the grid and rule memories are cleared
// one rule row per cycle over all 512 rule rows, during which
// s_axis_tready stays low.
// ----------------------------------------------------------------------------
module multi_ant_turmite_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] ant_sel, [7:2] col, [12:8] row, [21:13] rule_index,
    // [24:22] wdata, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    // [2:0] command
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] ant_id, [7:2] new_col, [12:8] new_row, [13] cell_value,
    // [15:14] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int RULE_AW = $clog2(mats_pkg::RULE_D);
    localparam int LANES_W = mats_pkg::ANT_N * mats_pkg::MOVE_W;

    // input item fields
    logic [mats_pkg::ANT_W-1:0]  in_sel;
    logic [mats_pkg::COL_W-1:0]  in_col;
    logic [mats_pkg::ROW_W-1:0]  in_row;
    logic [mats_pkg::CODE_W-1:0] in_ridx;
    logic [mats_pkg::MOVE_W-1:0] in_wdata;
    logic [mats_pkg::CMD_W-1:0]  in_cmd;

    assign in_sel   = s_axis_tdata[1:0];
    assign in_col   = s_axis_tdata[7:2];
    assign in_row   = s_axis_tdata[12:8];
    assign in_ridx  = s_axis_tdata[21:13];
    assign in_wdata = s_axis_tdata[24:22];
    assign in_cmd   = s_axis_tuser;

    // control and working registers
    mats_pkg::t_state r_state, n_state;
    logic [RULE_AW-1:0]          r_clr, n_clr;
    logic [mats_pkg::ANT_W-1:0]  r_ant, n_ant;
    logic [1:0]                  r_k, n_k;
    logic [mats_pkg::CODE_W-1:0] r_code, n_code;
    logic [mats_pkg::COL_W-1:0]  r_x, n_x;
    logic [mats_pkg::ROW_W-1:0]  r_y, n_y;
    logic [mats_pkg::COL_W-1:0]  r_col, n_col;
    logic [mats_pkg::ROW_W-1:0]  r_row, n_row;
    logic [mats_pkg::COL_W-1:0]  r_ant_x [mats_pkg::ANT_N];
    logic [mats_pkg::COL_W-1:0]  n_ant_x [mats_pkg::ANT_N];
    logic [mats_pkg::ROW_W-1:0]  r_ant_y [mats_pkg::ANT_N];
    logic [mats_pkg::ROW_W-1:0]  n_ant_y [mats_pkg::ANT_N];

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [mats_pkg::ANT_W-1:0]  r_out_ant, n_out_ant;
    logic [mats_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [mats_pkg::ROW_W-1:0]  r_out_row, n_out_row;
    logic                        r_out_cell, n_out_cell;
    logic                        r_out_last, n_out_last;
    logic                        out_free;

    // grid memory: one word per row
    logic [mats_pkg::GRID_W-1:0] r_grid_mem [mats_pkg::GRID_H];
    logic [mats_pkg::GRID_W-1:0] r_grid_rd;
    logic                        g_we, g_wrow, g_wbit;
    logic [mats_pkg::ROW_W-1:0]  g_waddr, g_raddr;
    logic [mats_pkg::COL_W-1:0]  g_wcol;

    // rule memory: one word per neighbourhood code, one lane per turmite
    logic [LANES_W-1:0]          r_rule_mem [mats_pkg::RULE_D];
    logic [LANES_W-1:0]          r_rule_rd;
    logic                        u_we, u_wrow;
    logic [RULE_AW-1:0]          u_waddr;
    logic [mats_pkg::ANT_W-1:0]  u_wlane;
    logic [mats_pkg::MOVE_W-1:0] u_wdata;

    logic [mats_pkg::COL_W-1:0]  xm, xp, nx;
    logic [mats_pkg::ROW_W-1:0]  ny;
    logic [mats_pkg::MOVE_W-1:0] mv;

    assign xm       = mats_pkg::wrap_col(r_x, mats_pkg::DIR_DEC);
    assign xp       = mats_pkg::wrap_col(r_x, mats_pkg::DIR_INC);
    assign mv       = r_rule_rd[r_ant*mats_pkg::MOVE_W +: mats_pkg::MOVE_W];
    assign nx       = mats_pkg::wrap_col(r_x, mats_pkg::MOVE_DC[mv]);
    assign ny       = mats_pkg::wrap_row(r_y, mats_pkg::MOVE_DR[mv]);
    assign out_free = !r_out_valid || m_axis_tready;

    // next state, memory controls and outputs
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ant       = r_ant;
        n_k         = r_k;
        n_code      = r_code;
        n_x         = r_x;
        n_y         = r_y;
        n_col       = r_col;
        n_row       = r_row;
        n_ant_x     = r_ant_x;
        n_ant_y     = r_ant_y;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ant   = r_out_ant;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_cell  = r_out_cell;
        n_out_last  = r_out_last;
        g_we        = 1'b0;
        g_wrow      = 1'b0;
        g_waddr     = r_row;
        g_wcol      = r_col;
        g_wbit      = 1'b0;
        g_raddr     = r_row;
        u_we        = 1'b0;
        u_wrow      = 1'b0;
        u_waddr     = in_ridx;
        u_wlane     = in_sel;
        u_wdata     = in_wdata;
        s_axis_tready = 1'b0;

        case (r_state)
            mats_pkg::ST_CLEAR: begin
                // zero one rule row, and one grid row while rows remain
                g_we    = int'(r_clr) < mats_pkg::GRID_H;
                g_wrow  = 1'b1;
                g_waddr = r_clr[mats_pkg::ROW_W-1:0];
                u_we    = 1'b1;
                u_wrow  = 1'b1;
                u_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == RULE_AW'(mats_pkg::RULE_D - 1)) begin
                    n_state = mats_pkg::ST_IDLE;
                end
            end
            mats_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (in_cmd)
                        mats_pkg::CMD_STEP: begin
                            n_ant   = '0;
                            n_state = mats_pkg::ST_LOAD;
                        end
                        mats_pkg::CMD_WCELL: begin
                            g_we    = mats_pkg::in_grid(in_col, in_row);
                            g_waddr = in_row;
                            g_wcol  = in_col;
                            g_wbit  = in_wdata[0];
                        end
                        mats_pkg::CMD_RCELL: begin
                            n_col   = in_col;
                            n_row   = in_row;
                            n_state = mats_pkg::ST_RDREQ;
                        end
                        mats_pkg::CMD_WRULE: begin
                            u_we = int'(in_sel) < mats_pkg::ANT_N;
                        end
                        mats_pkg::CMD_SETPOS: begin
                            if (int'(in_sel) < mats_pkg::ANT_N &&
                                mats_pkg::in_grid(in_col, in_row)) begin
                                n_ant_x[in_sel] = in_col;
                                n_ant_y[in_sel] = in_row;
                            end
                        end
                        default: begin
                            // unknown command: drop the item
                        end
                    endcase
                end
            end
            mats_pkg::ST_RDREQ: begin
                n_state = mats_pkg::ST_RDOUT;
            end
            mats_pkg::ST_RDOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ant   = '0;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_out_cell  = mats_pkg::in_grid(r_col, r_row) && r_grid_rd[r_col];
                    n_out_last  = 1'b1;
                    n_state     = mats_pkg::ST_IDLE;
                end
            end
            mats_pkg::ST_LOAD: begin
                n_x     = r_ant_x[r_ant];
                n_y     = r_ant_y[r_ant];
                n_k     = '0;
                n_code  = '0;
                n_state = mats_pkg::ST_NBR;
            end
            mats_pkg::ST_NBR: begin
                // issue row k, capture the row issued the cycle before
                g_raddr = mats_pkg::wrap_row(r_y, mats_pkg::t_dir'(r_k));
                case (r_k)
                    2'd1: begin
                        n_code[0] = r_grid_rd[xm];
                        n_code[3] = r_grid_rd[r_x];
                        n_code[6] = r_grid_rd[xp];
                    end
                    2'd2: begin
                        n_code[1] = r_grid_rd[xm];
                        n_code[4] = r_grid_rd[r_x];
                        n_code[7] = r_grid_rd[xp];
                    end
                    2'd3: begin
                        n_code[2] = r_grid_rd[xm];
                        n_code[5] = r_grid_rd[r_x];
                        n_code[8] = r_grid_rd[xp];
                    end
                    default: begin
                    end
                endcase
                n_k = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_state = mats_pkg::ST_RULE_RD;
                end
            end
            mats_pkg::ST_RULE_RD: begin
                n_state = mats_pkg::ST_MOVE;
            end
            mats_pkg::ST_MOVE: begin
                if (out_free) begin
                    // toggle the centre cell, its old value is code bit 4
                    g_we           = 1'b1;
                    g_waddr        = r_y;
                    g_wcol         = r_x;
                    g_wbit         = ~r_code[4];
                    n_ant_x[r_ant] = nx;
                    n_ant_y[r_ant] = ny;
                    n_out_valid    = 1'b1;
                    n_out_ant      = r_ant;
                    n_out_col      = nx;
                    n_out_row      = ny;
                    n_out_cell     = 1'b0;
                    n_out_last     = int'(r_ant) == mats_pkg::ANT_N - 1;
                    if (int'(r_ant) == mats_pkg::ANT_N - 1) begin
                        n_state = mats_pkg::ST_IDLE;
                    end else begin
                        n_ant   = r_ant + 1'b1;
                        n_state = mats_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = mats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mats_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_ant       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < mats_pkg::ANT_N; i++) begin
                r_ant_x[i] <= '0;
                r_ant_y[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ant       <= n_ant;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            r_ant_x     <= n_ant_x;
            r_ant_y     <= n_ant_y;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_x        <= n_x;
        r_y        <= n_y;
        r_col      <= n_col;
        r_row      <= n_row;
        r_out_ant  <= n_out_ant;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_cell <= n_out_cell;
        r_out_last <= n_out_last;
    end

    // grid memory port
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            if (g_wrow) begin
                r_grid_mem[g_waddr] <= '0;
            end else begin
                r_grid_mem[g_waddr][g_wcol] <= g_wbit;
            end
        end
        r_grid_rd <= r_grid_mem[g_raddr];
    end

    // rule memory port, read address follows the captured code
    always_ff @(posedge i_clk) begin
        if (u_we) begin
            if (u_wrow) begin
                r_rule_mem[u_waddr] <= '0;
            end else begin
                r_rule_mem[u_waddr][u_wlane*mats_pkg::MOVE_W +: mats_pkg::MOVE_W]
                    <= u_wdata;
            end
        end
        r_rule_rd <= r_rule_mem[r_code];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out_cell, r_out_row, r_out_col, r_out_ant};

endmodule

FILE: rtl/mats_checker.sv
// ----------------------------------------------------------------------------
// mats_checker
// Port-level checks for the turmite step core, bound to the top level.
// ----------------------------------------------------------------------------
module mats_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // hold a stalled result item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
    else $error("stalled result item changed");

    // memories are being cleared just after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
    else $error("input taken during clearing pass");

    // a step item keeps the input side closed on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == mats_pkg::CMD_STEP
            |=> !s_axis_tready)
    else $error("input reopened during a step");

    // a set cell bit only comes from a read result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tlast && m_axis_tdata[1:0] == 2'd0)
    else $error("cell bit set on a step result");

    // no result right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
    else $error("result item valid after reset");

endmodule

bind multi_ant_turmite_step_core mats_checker u_mats_checker (.*);

FILE: tb/multi_ant_turmite_step_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_ant_turmite_step_core_tb
// Drives cell, rule, position, read and step commands into the turmite core.
// A tracker keeps its own grid, rule tables and turmite positions, predicts
// every result item and compares each one field by field as it leaves.
// Both sides idle at random. One long result stall backs the core up.
// ----------------------------------------------------------------------------
module multi_ant_turmite_step_core_tb;

    // move codes, named by compass point; north is row - 1
    typedef enum bit [mats_pkg::MOVE_W-1:0] {
        MV_NW, MV_N, MV_NE, MV_W, MV_E, MV_SW, MV_S, MV_SE
    } t_move;

    // command codes that the core must ignore
    localparam bit [mats_pkg::CMD_W-1:0] CMD_BAD_LO = 3'd5;
    localparam bit [mats_pkg::CMD_W-1:0] CMD_BAD_HI = 3'd7;

    localparam int N_RANDOM   = 460;
    localparam int LONG_STALL = 600;  // cycles of receiver hold-off
    localparam int DRAIN_WAIT = 40;   // well above one step item

    typedef struct packed {
        logic [mats_pkg::ANT_W-1:0] ant_id;
        logic [mats_pkg::COL_W-1:0] new_col;
        logic [mats_pkg::ROW_W-1:0] new_row;
        logic                       cell_value;
        logic                       last;
    } t_report;

    // Own copy of the grid, the rule tables and the turmite positions.
    class turmite_tracker;
        bit                        grid_bits  [mats_pkg::GRID_H][mats_pkg::GRID_W];
        bit [mats_pkg::MOVE_W-1:0] move_rules [mats_pkg::ANT_N][mats_pkg::RULE_D];
        bit [mats_pkg::COL_W-1:0]  ant_col    [mats_pkg::ANT_N];
        bit [mats_pkg::ROW_W-1:0]  ant_row    [mats_pkg::ANT_N];
        t_report                   due_reports [$];
        int unsigned               faults;

        function bit [mats_pkg::COL_W-1:0] shift_col(bit [mats_pkg::COL_W-1:0] c, int d);
            if (d < 0)
                return (c == 0) ? mats_pkg::COL_W'(mats_pkg::GRID_W - 1) : c - 1'b1;
            if (d > 0) return (int'(c) + 1 >= mats_pkg::GRID_W) ? '0 : c + 1'b1;
            return c;
        endfunction

        function bit [mats_pkg::ROW_W-1:0] shift_row(bit [mats_pkg::ROW_W-1:0] r, int d);
            if (d < 0)
                return (r == 0) ? mats_pkg::ROW_W'(mats_pkg::GRID_H - 1) : r - 1'b1;
            if (d > 0) return (int'(r) + 1 >= mats_pkg::GRID_H) ? '0 : r + 1'b1;
            return r;
        endfunction

        function int col_delta(bit [mats_pkg::MOVE_W-1:0] mv);
            case (t_move'(mv))
                MV_NW, MV_W, MV_SW: return -1;
                MV_N, MV_S:         return 0;
                default:            return 1;
            endcase
        endfunction

        function int row_delta(bit [mats_pkg::MOVE_W-1:0] mv);
            case (t_move'(mv))
                MV_NW, MV_N, MV_NE: return -1;
                MV_W, MV_E:         return 0;
                default:            return 1;
            endcase
        endfunction

        // read the 3x3 code, look up the move, toggle the cell, then move
        function void advance_turmite(int a);
            int                        dx;
            int                        dy;
            bit [mats_pkg::CODE_W-1:0] code;
            bit [mats_pkg::MOVE_W-1:0] mv;
            bit [mats_pkg::COL_W-1:0]  cx;
            bit [mats_pkg::ROW_W-1:0]  cy;
            code = '0;
            for (dx = -1; dx <= 1; dx++) begin
                cx = shift_col(ant_col[a], dx);
                for (dy = -1; dy <= 1; dy++) begin
                    cy = shift_row(ant_row[a], dy);
                    code[3 * (dx + 1) + (dy + 1)] = grid_bits[cy][cx];
                end
            end
            mv = move_rules[a][code];
            grid_bits[ant_row[a]][ant_col[a]] ^= 1'b1;
            ant_col[a] = shift_col(ant_col[a], col_delta(mv));
            ant_row[a] = shift_row(ant_row[a], row_delta(mv));
        endfunction

        function void absorb_command(bit [mats_pkg::CMD_W-1:0] cmd, bit [31:0] data);
            bit [mats_pkg::ANT_W-1:0]  sel;
            bit [mats_pkg::COL_W-1:0]  col;
            bit [mats_pkg::ROW_W-1:0]  row;
            bit [mats_pkg::CODE_W-1:0] ridx;
            bit [mats_pkg::MOVE_W-1:0] wdata;
            bit                        on_grid;
            t_report                   rep;
            sel     = data[1:0];
            col     = data[7:2];
            row     = data[12:8];
            ridx    = data[21:13];
            wdata   = data[24:22];
            on_grid = (int'(col) < mats_pkg::GRID_W) && (int'(row) < mats_pkg::GRID_H);
            case (cmd)
                mats_pkg::CMD_STEP: begin
                    for (int a = 0; a < mats_pkg::ANT_N; a++) begin
                        advance_turmite(a);
                        rep.ant_id     = mats_pkg::ANT_W'(a);
                        rep.new_col    = ant_col[a];
                        rep.new_row    = ant_row[a];
                        rep.cell_value = 1'b0;
                        rep.last       = (a == mats_pkg::ANT_N - 1);
                        due_reports.push_back(rep);
                    end
                end
                mats_pkg::CMD_WCELL: begin
                    if (on_grid) grid_bits[row][col] = wdata[0];
                end
                mats_pkg::CMD_RCELL: begin
                    rep.ant_id     = '0;
                    rep.new_col    = col;
                    rep.new_row    = row;
                    rep.cell_value = on_grid ? grid_bits[row][col] : 1'b0;
                    rep.last       = 1'b1;
                    due_reports.push_back(rep);
                end
                mats_pkg::CMD_WRULE: begin
                    if (int'(sel) < mats_pkg::ANT_N) move_rules[sel][ridx] = wdata;
                end
                mats_pkg::CMD_SETPOS: begin
                    if (int'(sel) < mats_pkg::ANT_N && on_grid) begin
                        ant_col[sel] = col;
                        ant_row[sel] = row;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_fault(string what);
            faults++;
            if (faults <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
        endfunction

        function void compare_result(logic [15:0] data, logic last);
            t_report got;
            t_report want;
            got.ant_id     = data[1:0];
            got.new_col    = data[7:2];
            got.new_row    = data[12:8];
            got.cell_value = data[13];
            got.last       = last;
            if (due_reports.size() == 0) begin
                note_fault($sformatf("result %h/%b with nothing outstanding", data, last));
                return;
            end
            want = due_reports.pop_front();
            if (got.ant_id !== want.ant_id)
                note_fault($sformatf("ant_id expected %0d, got %0d",
                                     want.ant_id, got.ant_id));
            if (got.new_col !== want.new_col)
                note_fault($sformatf("new_col expected %0d, got %0d",
                                     want.new_col, got.new_col));
            if (got.new_row !== want.new_row)
                note_fault($sformatf("new_row expected %0d, got %0d",
                                     want.new_row, got.new_row));
            if (got.cell_value !== want.cell_value)
                note_fault($sformatf("cell_value expected %0b, got %0b",
                                     want.cell_value, got.cell_value));
            if (got.last !== want.last)
                note_fault($sformatf("tlast expected %0b, got %0b", want.last, got.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // ant_sel, col, row, rule_index, wdata, zeros
    logic [2:0]  s_axis_tuser;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // ant_id, new_col, new_row, cell_value, zeros
    logic        m_axis_tlast;

    turmite_tracker tracker;
    bit             send_burst;

    multi_ant_turmite_step_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Offer one item after a random gap and hold it until the core takes it.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_item(input bit [mats_pkg::CMD_W-1:0] cmd,
                              input bit [mats_pkg::ANT_W-1:0] sel,
                              input bit [mats_pkg::COL_W-1:0] col,
                              input bit [mats_pkg::ROW_W-1:0] row,
                              input bit [mats_pkg::CODE_W-1:0] ridx,
                              input bit [mats_pkg::MOVE_W-1:0] wdata);
        int gap;
        if ($urandom_range(24, 0) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(19, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, wdata, ridx, row, col, sel};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.absorb_command(cmd, {7'b0, wdata, ridx, row, col, sel});
        @(negedge i_clk);
    endtask

    // Mostly steps and cell traffic; half of the cell accesses land around a
    // turmite and half of the rule writes use sparse codes, so that the
    // entries the turmites really hit get rewritten often.
    task automatic random_item();
        int                        pick;
        int                        a;
        bit [mats_pkg::CMD_W-1:0]  cmd;
        bit [mats_pkg::ANT_W-1:0]  sel;
        bit [mats_pkg::COL_W-1:0]  col;
        bit [mats_pkg::ROW_W-1:0]  row;
        bit [mats_pkg::CODE_W-1:0] ridx;
        bit [mats_pkg::MOVE_W-1:0] wdata;
        pick  = $urandom_range(99, 0);
        sel   = mats_pkg::ANT_W'($urandom_range(mats_pkg::ANT_N - 1, 0));
        col   = mats_pkg::COL_W'($urandom_range(mats_pkg::GRID_W - 1, 0));
        row   = mats_pkg::ROW_W'($urandom_range(mats_pkg::GRID_H - 1, 0));
        ridx  = mats_pkg::CODE_W'($urandom_range(mats_pkg::RULE_D - 1, 0));
        wdata = mats_pkg::MOVE_W'($urandom_range(7, 0));
        if (pick < 38)      cmd = mats_pkg::CMD_STEP;
        else if (pick < 58) cmd = mats_pkg::CMD_WCELL;
        else if (pick < 76) cmd = mats_pkg::CMD_RCELL;
        else if (pick < 91) cmd = mats_pkg::CMD_WRULE;
        else if (pick < 97) cmd = mats_pkg::CMD_SETPOS;
        else                cmd = mats_pkg::CMD_W'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
        if ((cmd == mats_pkg::CMD_WCELL || cmd == mats_pkg::CMD_RCELL) &&
            $urandom_range(1, 0)) begin
            a   = $urandom_range(mats_pkg::ANT_N - 1, 0);
            col = tracker.ant_col[a] + mats_pkg::COL_W'($urandom_range(4, 0)) - 2'd2;
            row = tracker.ant_row[a] + mats_pkg::ROW_W'($urandom_range(4, 0)) - 2'd2;
        end
        if (cmd == mats_pkg::CMD_WRULE && $urandom_range(1, 0)) begin
            if ($urandom_range(3, 0) == 0)
                ridx = '0;
            else
                ridx = (mats_pkg::CODE_W'(1) << $urandom_range(mats_pkg::CODE_W - 1, 0))
                     | (mats_pkg::CODE_W'(1) << $urandom_range(mats_pkg::CODE_W - 1, 0));
        end
        offer_item(cmd, sel, col, row, ridx, wdata);
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off
    // that fills the core and pushes back on the sender.
    initial begin : result_sink
        int gap;
        int taken;
        bit burst;
        taken = 0;
        burst = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(24, 0) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(19, 0);
            if (taken == 120) gap = LONG_STALL;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    // Check every result item at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.compare_result(m_axis_tdata, m_axis_tlast);
    end

    initial begin : stimulus
        tracker       = new();
        send_burst    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // cell writes at both corners; wdata bits above bit 0 must be dropped
        offer_item(mats_pkg::CMD_WCELL, 2'd0, 6'd63, 5'd31, 9'd0, 3'd1);
        offer_item(mats_pkg::CMD_WCELL, 2'd3, 6'd0, 5'd0, 9'd511, 3'd7);
        offer_item(mats_pkg::CMD_WCELL, 2'd1, 6'd5, 5'd5, 9'd0, 3'd6);
        offer_item(mats_pkg::CMD_RCELL, 2'd3, 6'd63, 5'd31, 9'd511, 3'd7);
        offer_item(mats_pkg::CMD_RCELL, 2'd0, 6'd0, 5'd0, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_RCELL, 2'd0, 6'd5, 5'd5, 9'd0, 3'd0);
        // rule writes at both ends of the code range, every turmite
        offer_item(mats_pkg::CMD_WRULE, 2'd3, 6'd0, 5'd0, 9'd511, MV_SE);
        offer_item(mats_pkg::CMD_WRULE, 2'd0, 6'd0, 5'd0, 9'd0, MV_E);
        offer_item(mats_pkg::CMD_WRULE, 2'd1, 6'd0, 5'd0, 9'd0, MV_SE);
        offer_item(mats_pkg::CMD_WRULE, 2'd2, 6'd0, 5'd0, 9'd0, MV_NE);
        // park the turmites on the four corners to exercise every wrap
        offer_item(mats_pkg::CMD_SETPOS, 2'd0, 6'd63, 5'd31, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_SETPOS, 2'd1, 6'd0, 5'd0, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_SETPOS, 2'd2, 6'd63, 5'd0, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_SETPOS, 2'd3, 6'd0, 5'd31, 9'd0, 3'd0);
        // unknown commands with every field at its top value change nothing
        offer_item(CMD_BAD_LO, 2'd3, 6'd63, 5'd31, 9'd511, 3'd7);
        offer_item(CMD_BAD_HI, 2'd3, 6'd63, 5'd31, 9'd511, 3'd7);
        offer_item(mats_pkg::CMD_STEP, 2'd0, 6'd0, 5'd0, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_STEP, 2'd3, 6'd63, 5'd31, 9'd511, 3'd7);
        offer_item(mats_pkg::CMD_RCELL, 2'd0, 6'd63, 5'd31, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_WRULE, 2'd3, 6'd0, 5'd0, 9'd0, MV_W);
        offer_item(mats_pkg::CMD_STEP, 2'd0, 6'd0, 5'd0, 9'd0, 3'd0);
        offer_item(mats_pkg::CMD_RCELL, 2'd0, 6'd0, 5'd31, 9'd0, 3'd0);

        repeat (N_RANDOM) random_item();
        s_axis_tvalid <= 1'b0;

        // drain, then allow the core to settle before judging
        while (tracker.due_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (tracker.faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
